// ----- rtl/transfer_rate_limiter_and_meter_top_defines.svh -----
// assertion macros for the transfer rate limiter and meter
`ifndef TRANSFER_RATE_LIMITER_AND_METER_TOP_DEFINES_SVH
`define TRANSFER_RATE_LIMITER_AND_METER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TRLM_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define TRLM_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define TRLM_ASSERT_IMP(label, clk, rst, a, c, msg)
`define TRLM_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// ----- rtl/trlm_pkg.sv -----
// shared types and constants for the transfer rate limiter and meter
`timescale 1ns / 1ps
package trlm_pkg;
  localparam logic [1:0] REQ_NEW   = 2'd0;
  localparam logic [1:0] REQ_GRANT = 2'd1;
  localparam logic [1:0] REQ_ADD   = 2'd2;
  localparam logic [1:0] REQ_RATE  = 2'd3;
  localparam logic [9:0] MS_PER_SEC = 10'd1000;
  localparam logic [31:0] WRAP_SPAN = 32'd10000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SEC, ST_SAMPLE, ST_DIV, ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic exec;      // run new, grant or add step
    logic sec_start; // latch seconds number
    logic sample;    // ring update
    logic div_start; // start rate division
    logic finish;    // form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       div_busy;
    logic       div_done;
    logic [1:0] req;
    logic       need_sec;
    logic       need_rate;
  } status_t;
endpackage

// ----- rtl/trlm_div.sv -----
// restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps
module trlm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        busy,
  output logic        done
);
  logic [63:0] q;
  logic [32:0] rem;
  logic [6:0]  cnt;
  logic [31:0] dv;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[63]};
  assign quotient = q;

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= dividend;
        rem <= '0;
        dv <= divisor;
        cnt <= 7'd64;
      end else if (busy) begin
        if (trial >= {1'b0, dv}) begin
          rem <= trial - {1'b0, dv};
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/trlm_ctrl.sv -----
// controller state machine
`timescale 1ns / 1ps
module trlm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  trlm_pkg::status_t st,
  output trlm_pkg::cmd_t    cmd
);
  trlm_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= trlm_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      trlm_pkg::ST_IDLE: if (in_valid) begin
        state_next = trlm_pkg::ST_SEC;
      end
      trlm_pkg::ST_SEC: begin
        if (st.need_rate) state_next = trlm_pkg::ST_DIV;
        else state_next = trlm_pkg::ST_EXEC;
      end
      trlm_pkg::ST_DIV: if (st.div_done) begin
        state_next = trlm_pkg::ST_EXEC;
      end
      trlm_pkg::ST_EXEC: state_next = trlm_pkg::ST_SAMPLE;
      trlm_pkg::ST_SAMPLE: state_next = trlm_pkg::ST_OUT;
      trlm_pkg::ST_OUT: if (!out_stall) begin
        state_next = trlm_pkg::ST_IDLE;
      end
      default: state_next = trlm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = (state != trlm_pkg::ST_IDLE);
    out_valid = (state == trlm_pkg::ST_OUT);
    case (state)
      trlm_pkg::ST_IDLE: cmd.load = in_valid;
      trlm_pkg::ST_SEC: begin
        cmd.sec_start = st.need_sec;
        cmd.div_start = st.need_rate;
      end
      trlm_pkg::ST_EXEC: cmd.exec = 1'b1;
      trlm_pkg::ST_SAMPLE: begin
        cmd.sample = 1'b1;
        cmd.finish = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ----- rtl/trlm_dp.sv -----
// datapath: counters, budget, sample ring and rate
`timescale 1ns / 1ps
module trlm_dp #(
  parameter int BLOCK_MAX = 4096,
  parameter int WINDOW = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       cfg_limit,
  input  logic [1:0]        req_type,
  input  logic [31:0]       now_ms,
  input  logic [47:0]       amount,
  input  logic              add_to_totals,
  input  trlm_pkg::cmd_t    cmd,
  output trlm_pkg::status_t st,
  output logic [12:0]       grant_size,
  output logic              must_wait,
  output logic [31:0]       bytes_per_second,
  output logic              file_done
);
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [47:0] BMAX = 48'(BLOCK_MAX);
  localparam logic [47:0] SAT48 = {48{1'b1}};
  // ceil(2^38 / 1000), exact for every 32-bit tick value
  localparam logic [28:0] SEC_RECIP = 29'd274877907;

  logic [1:0]  req;
  logic [31:0] now;
  logic [47:0] amt;
  logic        tot;
  logic [47:0] file_size, file_bytes_done, total_bytes_done;
  logic [31:0] budget_left;
  logic [21:0] budget_second;
  logic [31:0] sample_time [WINDOW];
  logic [47:0] sample_total [WINDOW];
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [63:0] div_q;
  logic        div_start;
  logic [63:0] dividend;
  logic [31:0] divisor;
  logic [47:0] moved;
  logic [31:0] span;
  logic        rate_zero;
  logic [47:0] left, g0;
  logic [48:0] fsum, tsum;
  logic [47:0] fnew, tnew;
  logic [IW-1:0] last_idx, tail_idx, head_inc;
  logic [31:0] last_t;
  logic        take;
  logic [12:0] grant_r;
  logic        wait_r;
  logic [60:0] sec_prod;
  logic [21:0] sec_q;

  // ring indices
  always_comb begin
    logic [IW:0] s;
    s = {1'b0, head} + (IW + 1)'(count) - (IW + 1)'(1);
    last_idx = (s >= (IW + 1)'(WINDOW)) ? IW'(s - (IW + 1)'(WINDOW)) : IW'(s);
    s = {1'b0, head} + (IW + 1)'(count);
    tail_idx = (s >= (IW + 1)'(WINDOW)) ? IW'(s - (IW + 1)'(WINDOW)) : IW'(s);
    head_inc = (head == IW'(WINDOW - 1)) ? '0 : head + IW'(1);
  end
  assign last_t = sample_time[last_idx];

  // rate operands
  assign span = (now < sample_time[head]) ? trlm_pkg::WRAP_SPAN : now - sample_time[head];
  assign moved = total_bytes_done - sample_total[head];
  assign rate_zero = (count == '0) || (span == '0);

  // seconds number by reciprocal multiply, masked to 22 bits
  assign sec_prod = 61'(now) * 61'(SEC_RECIP);

  assign st.need_sec = (req == trlm_pkg::REQ_GRANT) && (cfg_limit != '0);
  assign st.need_rate = (req == trlm_pkg::REQ_RATE) && !rate_zero;
  assign st.req = req;
  assign div_start = cmd.div_start;
  // moved * 1000 as 1024 - 16 - 8
  assign dividend = ({16'd0, moved} << 10) - ({16'd0, moved} << 4) - ({16'd0, moved} << 3);
  assign divisor = span;

  trlm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend), .divisor(divisor),
    .quotient(div_q), .busy(st.div_busy), .done(st.div_done)
  );

  assign left = file_size - file_bytes_done;
  assign g0 = (left < BMAX) ? left : BMAX;
  assign fsum = {1'b0, file_bytes_done} + {1'b0, amt};
  assign fnew = fsum[48] ? SAT48 : fsum[47:0];
  assign tsum = {1'b0, total_bytes_done} + {1'b0, amt};
  assign tnew = tsum[48] ? SAT48 : tsum[47:0];
  assign take = (count == '0) || (last_t > now) ||
                ((now - last_t) >= 32'(trlm_pkg::MS_PER_SEC));

  // state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0; file_bytes_done <= '0; total_bytes_done <= '0;
      budget_left <= '0; budget_second <= '0; head <= '0; count <= '0;
    end else begin
      if (cmd.exec) begin
        case (req)
          trlm_pkg::REQ_NEW: begin
            file_size <= amt; file_bytes_done <= '0; budget_second <= '0;
          end
          trlm_pkg::REQ_GRANT: begin
            if (cfg_limit != '0) begin
              logic [31:0] b;
              logic [47:0] g;
              b = budget_left;
              if (sec_q != budget_second) begin
                b = cfg_limit;
                budget_second <= sec_q;
              end
              g = g0;
              if (b != '0) begin
                if (48'(b) < g) g = 48'(b);
                b = b - g[31:0];
              end
              budget_left <= b;
            end
          end
          trlm_pkg::REQ_ADD: begin
            file_bytes_done <= fnew;
            if (fnew > file_size) file_size <= fnew;
            if (tot) total_bytes_done <= tnew;
          end
          default: ;
        endcase
      end
      if (cmd.sample && req == trlm_pkg::REQ_ADD && tot && take) begin
        if (count < CW'(WINDOW)) count <= count + CW'(1);
        else head <= head_inc;
      end
    end
  end

  // sample ring writes, no reset
  always_ff @(posedge clk) begin
    if (cmd.sample && req == trlm_pkg::REQ_ADD && tot && take) begin
      if (count < CW'(WINDOW)) begin
        sample_time[tail_idx] <= now; sample_total[tail_idx] <= total_bytes_done;
      end else begin
        sample_time[head] <= now; sample_total[head] <= total_bytes_done;
      end
    end
  end

  // input capture and grant result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_type; now <= now_ms; amt <= amount; tot <= add_to_totals;
    end
    if (cmd.sec_start) sec_q <= sec_prod[59:38];
    if (cmd.exec) begin
      grant_r <= '0; wait_r <= 1'b0;
      if (req == trlm_pkg::REQ_GRANT) begin
        if (cfg_limit == '0) grant_r <= g0[12:0];
        else begin
          logic [31:0] b;
          b = (sec_q != budget_second) ? cfg_limit : budget_left;
          if (b == '0) wait_r <= 1'b1;
          else grant_r <= (48'(b) < g0) ? b[12:0] : g0[12:0];
        end
      end
    end
    if (cmd.finish) begin
      grant_size <= grant_r;
      must_wait <= wait_r;
      file_done <= (file_bytes_done == file_size);
      if (req == trlm_pkg::REQ_RATE && !rate_zero)
        bytes_per_second <= (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
      else bytes_per_second <= '0;
    end
  end
endmodule

// ----- rtl/transfer_rate_limiter_and_meter_top.sv -----
// top level of the transfer rate limiter and meter
`timescale 1ns / 1ps
`include "transfer_rate_limiter_and_meter_top_defines.svh"
// One item at a time: an item is accepted in idle and passes the seconds,
// exec, sample and output states before the next accept. A rate query with
// samples and a nonzero span also waits in divide for the bit-serial 64-by-32
// divider; limited grants get the seconds number from a reciprocal multiply.
module transfer_rate_limiter_and_meter_top #(
  parameter int BLOCK_MAX = 4096,
  parameter int WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic [47:0] amount,
  input  logic        add_to_totals,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] grant_size,
  output logic        must_wait,
  output logic [31:0] bytes_per_second,
  output logic        file_done
);
  logic [31:0] limit;
  trlm_pkg::cmd_t cmd;
  trlm_pkg::status_t st;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) limit <= '0;
    else if (cfg_we) limit <= cfg_wdata;
  end

  trlm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
  );

  trlm_dp #(.BLOCK_MAX(BLOCK_MAX), .WINDOW(WINDOW)) u_dp (
    .clk(clk), .rst(rst), .cfg_limit(limit), .req_type(req_type), .now_ms(now_ms),
    .amount(amount), .add_to_totals(add_to_totals), .cmd(cmd), .st(st),
    .grant_size(grant_size), .must_wait(must_wait),
    .bytes_per_second(bytes_per_second), .file_done(file_done)
  );

  // checks
  `TRLM_ASSERT_IMP(a_no_accept_busy, clk, rst, out_valid, in_stall, "accept while result held")
  `TRLM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  `TRLM_ASSERT_IMP(a_wait_no_grant, clk, rst, out_valid && must_wait, grant_size == '0, "grant on wait")
endmodule
